// ----- rtl/core/sfla_pkg.sv -----
// sfla_pkg: shared types and constants for the slab free list allocator.
// No dependencies; every rtl/core file refers to it by scoped names.
package sfla_pkg;

  localparam int MAX_OBJECTS = 1024;
  localparam int IDX_W       = $clog2(MAX_OBJECTS);   // entry index
  localparam int LINK_W      = IDX_W + 1;             // link / head, holds end marker
  localparam int CNT_W       = IDX_W + 1;             // counts 0..MAX_OBJECTS
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 16;
  localparam int CFG_CNT_W   = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [LINK_W-1:0] LIST_END = {LINK_W{1'b1}};
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_OBJECTS);

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd16;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NOMEM    = 2'd2,
    ST_INTERNAL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_ALLOC_UPD,
    S_FREE,
    S_FREE_DIV,
    S_FREE_RD,
    S_FREE_UPD,
    S_RESP
  } state_t;

  // write request into the link store
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic              taken;
    logic [LINK_W-1:0] link;
  } store_wr_t;

  // read result from the link store
  typedef struct packed {
    logic              taken;
    logic [LINK_W-1:0] link;
  } store_rd_t;

endpackage

// ----- rtl/core/sfla_div.sv -----
// sfla_div: restoring divider, one quotient bit per cycle.
// Depends on sfla_pkg for widths.
module sfla_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sfla_pkg::ADDR_W-1:0]  dividend,
  input  logic [sfla_pkg::SIZE_W-1:0]  divisor,
  output logic                         done,
  output logic [sfla_pkg::ADDR_W-1:0]  quot,
  output logic [sfla_pkg::SIZE_W-1:0]  rem
);

  localparam int STEP_W = $clog2(sfla_pkg::ADDR_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           cnt_r, cnt_nxt;
  logic [sfla_pkg::ADDR_W-1:0] quo_r, quo_nxt;
  logic [sfla_pkg::SIZE_W-1:0] rem_r, rem_nxt;
  logic [sfla_pkg::SIZE_W-1:0] dsr_r, dsr_nxt;

  logic [sfla_pkg::SIZE_W:0]   shifted;
  logic [sfla_pkg::SIZE_W:0]   diff;
  logic                        ge;

  assign shifted = {rem_r, quo_r[sfla_pkg::ADDR_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = {STEP_W{1'b1}};
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[sfla_pkg::SIZE_W-1:0] : shifted[sfla_pkg::SIZE_W-1:0];
      quo_nxt = {quo_r[sfla_pkg::ADDR_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/core/sfla_store.sv -----
// sfla_store: link and allocated-flag memory, one write and one registered read port.
// Entries at or above the fresh watermark read as the untouched ascending chain.
// Depends on sfla_pkg.
module sfla_store (
  input  logic                        clk,
  input  sfla_pkg::store_wr_t         wr,
  input  logic                        rd_en,
  input  logic [sfla_pkg::IDX_W-1:0]  rd_addr,
  input  logic [sfla_pkg::CNT_W-1:0]  wmark,
  input  logic [sfla_pkg::CNT_W-1:0]  live_count,
  output sfla_pkg::store_rd_t         rd
);

  localparam int WORD_W = sfla_pkg::LINK_W + 1;

  logic [WORD_W-1:0]          mem [sfla_pkg::MAX_OBJECTS];
  logic [WORD_W-1:0]          rd_q_r;
  logic [sfla_pkg::IDX_W-1:0] rd_addr_r;

  logic [sfla_pkg::CNT_W-1:0] succ;
  logic                       fresh;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.taken, wr.link};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // never-touched entries: not taken, linked to the next index
  assign succ  = {1'b0, rd_addr_r} + 1'b1;
  assign fresh = {1'b0, rd_addr_r} >= wmark;

  always_comb begin
    if (fresh) begin
      rd.taken = 1'b0;
      rd.link  = (succ < live_count) ? sfla_pkg::LINK_W'(succ) : sfla_pkg::LIST_END;
    end else begin
      rd.taken = rd_q_r[WORD_W-1];
      rd.link  = rd_q_r[sfla_pkg::LINK_W-1:0];
    end
  end

endmodule

// ----- rtl/core/slab_free_list_allocator.sv -----
// slab_free_list_allocator: top level, request sequencer and configuration registers.
// Depends on sfla_pkg, sfla_div and sfla_store.
//
// Usage
//   Input channel (in_valid / in_stall, in_op, in_object_address): one request per
//   transaction. in_stall is high while a request is being worked on.
//   Result channel (out_valid / out_stall, out_status, out_alloc_address): exactly
//   one result transaction per request, in request order. The result sits in an
//   output register, so the next request is taken while it waits to be drained.
//   Config port (cfg_we, cfg_index, cfg_wdata): 0 base address, 1 object size,
//   2 object count (applied by the next init). Write only while idle.
// Sequence from request accepted to result valid (output register empty):
//   init / unused op : straight to the response state; allocate: link RAM read, then update
//   free             : the 32-step serial divider turns the byte offset into an
//                      entry index and remainder, then link RAM read and update;
//                      read and update are skipped when the quotient or remainder
//                      rejects the address, the divider too for zero size or an address below base.
// A new request is taken only after the previous one has loaded its result, at the earliest in the cycle after.
// Reset: empty list (count 0), base 0, size 16, no result pending.
// The link RAM needs no clearing pass: a watermark marks how far the ascending
// chain has been consumed since init; entries at or above it read as the fresh chain.
// A stalled result holds; a finished request waits in the response state for it.
module slab_free_list_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_op,
  input  logic [sfla_pkg::ADDR_W-1:0]     in_object_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [sfla_pkg::ADDR_W-1:0]     out_alloc_address,
  input  logic                            cfg_we,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfla_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PROD_W = sfla_pkg::IDX_W + sfla_pkg::SIZE_W;

  // config registers
  logic [sfla_pkg::ADDR_W-1:0]    base_r;
  logic [sfla_pkg::SIZE_W-1:0]    size_r;
  logic [sfla_pkg::CFG_CNT_W-1:0] count_r;

  // allocator state
  sfla_pkg::state_t            state_r, state_nxt;
  logic [sfla_pkg::CNT_W-1:0]  live_r, live_nxt;
  logic [sfla_pkg::LINK_W-1:0] head_r, head_nxt;
  logic [sfla_pkg::CNT_W-1:0]  wmark_r, wmark_nxt;

  // per-transaction working registers
  logic [sfla_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [sfla_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [PROD_W-1:0]           prod_r, prod_nxt;
  sfla_pkg::status_t           res_st_r, res_st_nxt;
  logic [sfla_pkg::ADDR_W-1:0] res_addr_r, res_addr_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  sfla_pkg::status_t           out_st_r, out_st_nxt;
  logic [sfla_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;

  // divider and link store
  logic                        div_start;
  logic                        div_done;
  logic [sfla_pkg::ADDR_W-1:0] div_quot;
  logic [sfla_pkg::SIZE_W-1:0] div_rem;
  sfla_pkg::store_wr_t         st_wr;
  sfla_pkg::store_rd_t         st_rd;
  logic                        st_rd_en;
  logic [sfla_pkg::IDX_W-1:0]  st_rd_addr;

  logic                        in_acc;
  logic [sfla_pkg::CNT_W-1:0]  count_ext;

  assign in_stall  = (state_r != sfla_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign count_ext = count_r;

  sfla_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (addr_r - base_r),
    .divisor  (size_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  sfla_store u_store (
    .clk        (clk),
    .wr         (st_wr),
    .rd_en      (st_rd_en),
    .rd_addr    (st_rd_addr),
    .wmark      (wmark_r),
    .live_count (live_r),
    .rd         (st_rd)
  );

  // config writes (the user writes only while idle; the block itself does not enforce it)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      size_r  <= sfla_pkg::SIZE_RESET;
      count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfla_pkg::CFG_BASE:  base_r  <= cfg_wdata;
        sfla_pkg::CFG_SIZE:  size_r  <= cfg_wdata[sfla_pkg::SIZE_W-1:0];
        sfla_pkg::CFG_COUNT: count_r <= cfg_wdata[sfla_pkg::CFG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    live_nxt     = live_r;
    head_nxt     = head_r;
    wmark_nxt    = wmark_r;
    addr_nxt     = addr_r;
    idx_nxt      = idx_r;
    prod_nxt     = prod_r;
    res_st_nxt   = res_st_r;
    res_addr_nxt = res_addr_r;
    div_start    = 1'b0;
    st_rd_en     = 1'b0;
    st_rd_addr   = idx_r;
    st_wr        = '0;
    // output slot drains independently of the sequencer
    out_valid_nxt = out_valid_r && out_stall;
    out_st_nxt    = out_st_r;
    out_addr_nxt  = out_addr_r;

    unique case (state_r)
      sfla_pkg::S_IDLE: begin
        if (in_acc) begin
          addr_nxt     = in_object_address;
          res_st_nxt   = sfla_pkg::ST_INVALID;
          res_addr_nxt = '0;
          unique case (sfla_pkg::op_t'(in_op))
            sfla_pkg::OP_ALLOC: state_nxt = sfla_pkg::S_ALLOC;
            sfla_pkg::OP_FREE:  state_nxt = sfla_pkg::S_FREE;
            sfla_pkg::OP_INIT: begin
              // rebuild: saturate the count, restart the fresh chain
              live_nxt   = (count_ext > sfla_pkg::MAX_CNT) ? sfla_pkg::MAX_CNT : count_ext;
              head_nxt   = (live_nxt == '0) ? sfla_pkg::LIST_END : '0;
              wmark_nxt  = '0;
              res_st_nxt = sfla_pkg::ST_OK;
              state_nxt  = sfla_pkg::S_RESP;
            end
            default: state_nxt = sfla_pkg::S_RESP;
          endcase
        end
      end

      sfla_pkg::S_ALLOC: begin
        if (size_r == '0) begin
          res_st_nxt = sfla_pkg::ST_INVALID;
          state_nxt  = sfla_pkg::S_RESP;
        end else if (head_r == sfla_pkg::LIST_END) begin
          res_st_nxt = sfla_pkg::ST_NOMEM;
          state_nxt  = sfla_pkg::S_RESP;
        end else if ({1'b0, head_r} >= {1'b0, live_r}) begin
          res_st_nxt = sfla_pkg::ST_INTERNAL;
          state_nxt  = sfla_pkg::S_RESP;
        end else begin
          idx_nxt    = head_r[sfla_pkg::IDX_W-1:0];
          st_rd_en   = 1'b1;
          st_rd_addr = head_r[sfla_pkg::IDX_W-1:0];
          prod_nxt   = head_r[sfla_pkg::IDX_W-1:0] * size_r;
          state_nxt  = sfla_pkg::S_ALLOC_UPD;
        end
      end

      sfla_pkg::S_ALLOC_UPD: begin
        head_nxt     = st_rd.link;
        st_wr.en     = 1'b1;
        st_wr.addr   = idx_r;
        st_wr.taken  = 1'b1;
        st_wr.link   = st_rd.link;
        if ({1'b0, idx_r} == wmark_r) begin
          wmark_nxt = wmark_r + 1'b1;
        end
        res_addr_nxt = base_r + sfla_pkg::ADDR_W'(prod_r);
        res_st_nxt   = sfla_pkg::ST_OK;
        state_nxt    = sfla_pkg::S_RESP;
      end

      sfla_pkg::S_FREE: begin
        if (size_r == '0 || addr_r < base_r) begin
          state_nxt = sfla_pkg::S_RESP;
        end else begin
          div_start = 1'b1;
          state_nxt = sfla_pkg::S_FREE_DIV;
        end
      end

      sfla_pkg::S_FREE_DIV: begin
        if (div_done) begin
          if (div_rem != '0 || div_quot >= sfla_pkg::ADDR_W'(live_r)) begin
            state_nxt = sfla_pkg::S_RESP;
          end else begin
            idx_nxt   = div_quot[sfla_pkg::IDX_W-1:0];
            state_nxt = sfla_pkg::S_FREE_RD;
          end
        end
      end

      sfla_pkg::S_FREE_RD: begin
        st_rd_en   = 1'b1;
        st_rd_addr = idx_r;
        state_nxt  = sfla_pkg::S_FREE_UPD;
      end

      sfla_pkg::S_FREE_UPD: begin
        // double free leaves everything untouched
        if (st_rd.taken) begin
          st_wr.en    = 1'b1;
          st_wr.addr  = idx_r;
          st_wr.taken = 1'b0;
          st_wr.link  = head_r;
          head_nxt    = {1'b0, idx_r};
          res_st_nxt  = sfla_pkg::ST_OK;
        end
        state_nxt = sfla_pkg::S_RESP;
      end

      sfla_pkg::S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_addr_nxt  = res_addr_r;
          state_nxt     = sfla_pkg::S_IDLE;
        end
      end

      default: state_nxt = sfla_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfla_pkg::S_IDLE;
      live_r      <= '0;
      head_r      <= sfla_pkg::LIST_END;
      wmark_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      head_r      <= head_nxt;
      wmark_r     <= wmark_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    idx_r      <= idx_nxt;
    prod_r     <= prod_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    out_st_r   <= out_st_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_st_r;
  assign out_alloc_address = out_addr_r;

endmodule

// ----- rtl/core/sfla_checker.sv -----
// sfla_checker: port-level assertions for slab_free_list_allocator, bound to the top.
// Depends on sfla_pkg.
module sfla_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_status,
  input logic [sfla_pkg::ADDR_W-1:0] out_alloc_address
);

  // a result left waiting holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
                               && $stable(out_alloc_address))
    else $error("stalled result changed");

  // an accepted request leaves the block busy in the cycle after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // only a successful transaction carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sfla_pkg::ST_OK |-> out_alloc_address == '0)
    else $error("address on failed transaction");

  // reset leaves the block idle with nothing pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind slab_free_list_allocator sfla_checker u_sfla_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_alloc_address (out_alloc_address)
);

// ----- tb/alloc_reply_checker.sv -----
// alloc_reply_checker: watches the request, result and register ports of the slab allocator,
// predicts every result and compares it. Depends on sfla_pkg for field types and codes.
`timescale 1ns / 100ps
module alloc_reply_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      in_op,
  input  logic [sfla_pkg::ADDR_W-1:0]     in_object_address,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      out_status,
  input  logic [sfla_pkg::ADDR_W-1:0]     out_alloc_address,
  input  logic                            cfg_we,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfla_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              replies_outstanding
);
  import sfla_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr;
  } alloc_reply_t;

  // shadow registers and shadow free list
  logic [ADDR_W-1:0]    base_q;
  logic [SIZE_W-1:0]    size_q;
  logic [CFG_CNT_W-1:0] count_cfg_q;
  logic [CNT_W-1:0]     live_count;
  logic [LINK_W-1:0]    head;
  logic [LINK_W-1:0]    link_mem [MAX_OBJECTS];
  logic                 taken_mem [MAX_OBJECTS];

  alloc_reply_t expected_replies [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    fail_count++;
  endtask

  function automatic void rebuild_chain();
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      link_mem[i]  = (i + 1 < live_count) ? LINK_W'(i + 1) : LIST_END;
      taken_mem[i] = 1'b0;
    end
    head = (live_count == '0) ? LIST_END : '0;
  endfunction

  task automatic predict_request(input op_t op, input logic [ADDR_W-1:0] addr);
    alloc_reply_t      reply;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] quot;
    logic [ADDR_W-1:0] rem;
    logic [IDX_W-1:0]  slot;
    reply.status = ST_INVALID;
    reply.addr   = '0;
    case (op)
      OP_INIT: begin
        live_count = (count_cfg_q > CFG_CNT_W'(MAX_OBJECTS)) ? MAX_CNT : CNT_W'(count_cfg_q);
        rebuild_chain();
        reply.status = ST_OK;
      end
      OP_ALLOC: begin
        if (size_q == '0) begin
          reply.status = ST_INVALID;
        end else if (head == LIST_END) begin
          reply.status = ST_NOMEM;
        end else if (CNT_W'(head) >= live_count) begin
          reply.status = ST_INTERNAL;
        end else begin
          slot            = head[IDX_W-1:0];
          head            = link_mem[slot];
          taken_mem[slot] = 1'b1;
          reply.addr      = base_q + ADDR_W'(slot) * ADDR_W'(size_q);
          reply.status    = ST_OK;
        end
      end
      OP_FREE: begin
        if (size_q != '0 && addr >= base_q) begin
          offset = addr - base_q;
          quot   = offset / ADDR_W'(size_q);
          rem    = offset % ADDR_W'(size_q);
          if (rem == '0 && quot < ADDR_W'(live_count)) begin
            slot = quot[IDX_W-1:0];
            if (taken_mem[slot]) begin
              taken_mem[slot] = 1'b0;
              link_mem[slot]  = head;
              head            = {1'b0, slot};
              reply.status    = ST_OK;
            end
          end
        end
      end
      default: ;
    endcase
    expected_replies.push_back(reply);
  endtask

  always @(posedge clk) begin
    alloc_reply_t want;
    if (!rst_n) begin
      base_q      = '0;
      size_q      = SIZE_RESET;
      count_cfg_q = '0;
      live_count  = '0;
      rebuild_chain();
      expected_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: status %0d addr %h",
                                    out_status, out_alloc_address));
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                      out_status, want.status, want.status.name()));
          end
          if (out_alloc_address !== want.addr) begin
            report_mismatch($sformatf("alloc_address %h, expected %h",
                                      out_alloc_address, want.addr));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE:  base_q      = cfg_wdata[ADDR_W-1:0];
          CFG_SIZE:  size_q      = cfg_wdata[SIZE_W-1:0];
          CFG_COUNT: count_cfg_q = cfg_wdata[CFG_CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_request(op_t'(in_op), in_object_address);
      end
    end
    replies_outstanding <= expected_replies.size();
  end

endmodule

// ----- tb/slab_free_list_allocator_tb.sv -----
// slab_free_list_allocator_tb: stimulus and verdict for the slab free list allocator.
// Depends on sfla_pkg, the allocator RTL and alloc_reply_checker.
`timescale 1ns / 100ps
module slab_free_list_allocator_tb;
  import sfla_pkg::*;

  localparam int RESET_CYCLES = 5;
  localparam int ITEM_TARGET  = 1750;
  // the limit sits well above the slowest legal run (free latency + gaps + stalls)
  localparam int CYCLE_LIMIT  = 800000;
  // settle time after the last result; covers the free path latency
  localparam int TAIL_CYCLES  = 48;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_op             = OP_ALLOC;
  logic [ADDR_W-1:0]     in_object_address = '0;
  logic                  out_valid;
  logic                  out_stall         = 1'b0;
  logic [1:0]            out_status;
  logic [ADDR_W-1:0]     out_alloc_address;
  logic                  cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = CFG_BASE;
  logic [CFG_DATA_W-1:0] cfg_wdata         = '0;

  int fail_count;
  int replies_outstanding;
  int cycle_count = 0;
  int requests_sent = 0;
  int burst_left = 0;

  // what the stimulus side believes about the allocator's setup
  logic [ADDR_W-1:0]    cur_base  = '0;
  logic [SIZE_W-1:0]    cur_size  = SIZE_RESET;
  logic [CFG_CNT_W-1:0] cur_count = '0;
  int                   eff_count = 0;   // count latched by the last init
  int                   allocs_seen = 0; // allocates since the last init

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  slab_free_list_allocator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_object_address (in_object_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_alloc_address (out_alloc_address),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  alloc_reply_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_object_address   (in_object_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_alloc_address   (out_alloc_address),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .fail_count          (fail_count),
    .replies_outstanding (replies_outstanding)
  );

  // Result-side backpressure: a mode is held for a random stretch, then redrawn.
  // Modes: never stall, light random, heavy random, fixed periodic pattern.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 8) < 3);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One request transaction. Valid stays high across a burst; between bursts a
  // random gap drops it. A zero gap keeps valid high so it is never lowered and
  // raised in the same step.
  task automatic send(input op_t op, input logic [ADDR_W-1:0] addr);
    int gap;
    in_valid          <= 1'b1;
    in_op             <= op;
    in_object_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    if (op == OP_INIT) begin
      eff_count   = (cur_count > CFG_CNT_W'(MAX_OBJECTS)) ? MAX_OBJECTS : int'(cur_count);
      allocs_seen = 0;
    end else if (op == OP_ALLOC) begin
      allocs_seen++;
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Block goes idle: valid low, every result drained, then a settle window.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back; bits above the size and count fields are junk.
  task automatic load_config(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                             input logic [CFG_CNT_W-1:0] count);
    logic [31:0] junk;
    junk      = $urandom();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_SIZE;
    cfg_wdata <= {junk[31:16], size};
    @(posedge clk);
    cfg_index <= CFG_COUNT;
    cfg_wdata <= {junk[31:11], count};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_base  = base;
    cur_size  = size;
    cur_count = count;
  endtask

  function automatic logic [ADDR_W-1:0] slot_address(input int k);
    return cur_base + ADDR_W'(k) * ADDR_W'(cur_size);
  endfunction

  // One random phase: new setup, usually an init, then a mix weighted toward
  // well-formed alloc/free traffic so the list gets deep, plus some noise.
  task automatic run_random_phase();
    logic [ADDR_W-1:0]    base;
    logic [SIZE_W-1:0]    size;
    logic [CFG_CNT_W-1:0] count;
    int n_items;
    int r;
    int k;
    int hi;

    case ($urandom_range(0, 9))
      0, 1, 2, 3: base = '0;
      4, 5, 6:    base = $urandom();
      7:          base = 32'hFFFF_FFFF - $urandom_range(0, 4095);
      8:          base = 32'hFFFF_FFFF;
      default:    base = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 15))
      0:          size = '0;
      1:          size = 16'hFFFF;
      2, 3:       size = SIZE_W'(1 << $urandom_range(0, 15));
      4:          size = SIZE_W'($urandom());
      default:    size = SIZE_W'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 15))
      0:          count = '0;
      1:          count = 11'd1;
      2:          count = CFG_CNT_W'(MAX_OBJECTS);
      3:          count = 11'h7FF;
      4:          count = CFG_CNT_W'($urandom_range(0, 2047));
      default:    count = CFG_CNT_W'($urandom_range(1, 48));
    endcase
    load_config(base, size, count);
    // now and then keep the old list and only move base / size under it
    if ($urandom_range(0, 4) != 0) send(OP_INIT, $urandom());

    n_items = $urandom_range(30, 120);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send(OP_ALLOC, $urandom());
      end else if (r < 80) begin
        // address of a slot that was probably handed out; some are double frees
        hi = (allocs_seen < eff_count) ? allocs_seen : eff_count;
        k  = $urandom_range(0, hi);
        send(OP_FREE, slot_address(k));
      end else if (r < 86) begin
        k = $urandom_range(0, (eff_count > 0) ? eff_count - 1 : 0);
        if (cur_size > 1) send(OP_FREE, slot_address(k) + $urandom_range(1, cur_size - 1));
        else send(OP_FREE, $urandom());
      end else if (r < 90) begin
        if (r[0]) send(OP_FREE, cur_base - $urandom_range(1, 64));
        else send(OP_FREE, slot_address(eff_count + $urandom_range(0, 2)));
      end else if (r < 95) begin
        send(OP_FREE, $urandom());
      end else if (r < 97) begin
        send(OP_RSVD, $urandom());
      end else begin
        send(OP_INIT, $urandom());
      end
    end
    drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: empty list, unused op, empty init
    send(OP_ALLOC, 32'h0);
    send(OP_FREE, 32'h0);
    send(OP_RSVD, 32'hFFFF_FFFF);
    send(OP_INIT, 32'h0);
    drain();

    // small region: fill, run dry, bad frees (below base, misaligned, past the count), double free, reuse
    load_config(32'h0000_1000, 16'd16, 11'd3);
    send(OP_INIT, 32'h0);
    send(OP_ALLOC, 32'h0);
    send(OP_ALLOC, 32'h0);
    send(OP_ALLOC, 32'h0);
    send(OP_ALLOC, 32'h0);
    send(OP_FREE, 32'h0000_0FF0);   // below base
    send(OP_FREE, 32'h0000_1008);   // misaligned
    send(OP_FREE, 32'h0000_1030);   // index past the count
    send(OP_FREE, 32'h0000_1010);
    send(OP_FREE, 32'h0000_1010);   // double free
    send(OP_ALLOC, 32'h0);
    drain();

    // zero object size: alloc and free refused, init still fine
    load_config(32'h0000_1000, 16'd0, 11'd3);
    send(OP_ALLOC, 32'h0);
    send(OP_FREE, 32'h0000_1000);
    send(OP_INIT, 32'h0);
    drain();

    // top of address space, largest size, count saturates at MAX_OBJECTS
    load_config(32'hFFFF_FFF0, 16'hFFFF, 11'h7FF);
    send(OP_INIT, 32'h0);
    send(OP_ALLOC, 32'h0);
    send(OP_ALLOC, 32'h0);          // address wraps past 2^32
    send(OP_FREE, 32'h0000_FFEF);   // wrapped address reads as below base
    send(OP_FREE, 32'hFFFF_FFF0);
    send(OP_FREE, 32'hFFFF_FFFF);
    drain();

    load_config(32'h0, 16'd1, CFG_CNT_W'(MAX_OBJECTS));
    send(OP_INIT, 32'h0);
    send(OP_ALLOC, 32'h0);
    drain();

    while (requests_sent < ITEM_TARGET) run_random_phase();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
